>>> rtl/servo_led_command_decoder_top_defines.svh
// Assertion macros shared by the servo and LED command decoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SERVO_LED_COMMAND_DECODER_TOP_DEFINES_SVH
`define SERVO_LED_COMMAND_DECODER_TOP_DEFINES_SVH

`define SLED_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define SLED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SLED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sled_pkg.sv
`timescale 1ns / 1ps

package sled_pkg;

    localparam int BYTE_W    = 8;
    localparam int CENTER_W  = 16;
    localparam int STEP_W    = 8;
    localparam int CHAN_W    = 2;
    localparam int POS_W     = 3;
    localparam int CMD_LEN   = 5;
    localparam int HELD_LEN  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CENTER_W-1:0] CENTER_RESET = 16'd2999;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;

    localparam logic KIND_SERVO = 1'b0;
    localparam logic KIND_LED   = 1'b1;

    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_L     = 8'h4C;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_1     = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_2     = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

    typedef logic [CMD_LEN-1:0][BYTE_W-1:0] cmd_t;

    typedef struct packed {
        logic                command_valid;
        logic                target_kind;
        logic [CHAN_W-1:0]   channel;
        logic [CENTER_W-1:0] compare_value;
        logic                led_level;
    } res_t;

endpackage

>>> rtl/sled_ifs.sv
`timescale 1ns / 1ps

interface sled_rx_if
    import sled_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sled_res_if
    import sled_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command_valid;
    logic                target_kind;
    logic [CHAN_W-1:0]   channel;
    logic [CENTER_W-1:0] compare_value;
    logic                led_level;

    modport source (
        output valid, output command_valid, output target_kind, output channel,
        output compare_value, output led_level, input ready
    );
    modport sink (
        input valid, input command_valid, input target_kind, input channel,
        input compare_value, input led_level, output ready
    );
endinterface

interface sled_cfg_if
    import sled_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sled_decode.sv
`timescale 1ns / 1ps

module sled_decode
    import sled_pkg::*;
(
    input  cmd_t                cmd,
    input  logic [CENTER_W-1:0] center,
    input  logic [STEP_W-1:0]   step,
    output res_t                result
);

    logic        d3_ok;
    logic        d4_ok;
    logic        angle_ok;
    logic [3:0]  d3;
    logic [3:0]  d4;
    logic [6:0]  angle;
    logic [14:0] delta;
    logic [16:0] sum;
    logic [16:0] diff;
    logic [CENTER_W-1:0] servo_value;

    assign d3_ok = (cmd[3] >= CHAR_0) && (cmd[3] <= CHAR_9);
    assign d4_ok = (cmd[4] >= CHAR_0) && (cmd[4] <= CHAR_9);
    // Ninety is the largest angle, so a leading nine allows only a trailing zero.
    assign angle_ok = d3_ok && ((cmd[3] == CHAR_9) ? (cmd[4] == CHAR_0) : d4_ok);

    assign d3 = cmd[3][3:0];
    assign d4 = cmd[4][3:0];
    assign angle = 7'({3'b000, d3} * 7'd10) + {3'b000, d4};
    assign delta = 15'({7'b0, step} * {8'b0, angle});
    assign sum = {1'b0, center} + {2'b00, delta};
    assign diff = {1'b0, center} - {2'b00, delta};

    always_comb
    begin
        if (cmd[2] == CHAR_PLUS)
        begin
            servo_value = sum[16] ? {CENTER_W{1'b1}} : sum[CENTER_W-1:0];
        end
        else
        begin
            servo_value = diff[16] ? '0 : diff[CENTER_W-1:0];
        end
    end

    always_comb
    begin
        result = '0;
        priority if (cmd[0] == CHAR_S)
        begin
            if ((cmd[1] >= CHAR_0) && (cmd[1] <= CHAR_2)
                && ((cmd[2] == CHAR_PLUS) || (cmd[2] == CHAR_MINUS)) && angle_ok)
            begin
                result.command_valid = 1'b1;
                result.target_kind   = KIND_SERVO;
                result.channel       = cmd[1][CHAN_W-1:0];
                result.compare_value = servo_value;
            end
        end
        else if (cmd[0] == CHAR_L)
        begin
            if (((cmd[1] == CHAR_0) || (cmd[1] == CHAR_1)) && (cmd[2] == CHAR_O)
                && (((cmd[3] == CHAR_N) && (cmd[4] == CHAR_N))
                    || ((cmd[3] == CHAR_F) && (cmd[4] == CHAR_F))))
            begin
                result.command_valid = 1'b1;
                result.target_kind   = KIND_LED;
                result.channel       = cmd[1][CHAN_W-1:0];
                result.led_level     = (cmd[3] == CHAR_N);
            end
        end
        else
        begin
            result = '0;
        end
    end

endmodule

>>> rtl/servo_led_command_decoder_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload                                            Results
// rx       in         rx_byte                                            -
// res      out        command_valid, target_kind, channel,               one per fifth byte
//                     compare_value, led_level
// cfg      in         index, data (center_count, step_per_degree)        -
//
// One byte is accepted per cycle unless a fifth byte waits on a stalled output; the fifth
// byte of a command is captured in a command register and its result is then loaded
// into the output register when the output is free. Reset clears the character position
// and valid flags and sets center and step to their reset values; data is not reset.
// A stalled output holds the command register; only a fifth byte then waits.

`include "servo_led_command_decoder_top_defines.svh"

module servo_led_command_decoder_top
    import sled_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sled_rx_if.sink   rx,
    sled_res_if.source res,
    sled_cfg_if.sink  cfg
);

    logic [BYTE_W-1:0]   held_reg [HELD_LEN];
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    cmd_t                s1_cmd_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    res_t                res_data_reg;
    res_t                dec_result;
    logic [CENTER_W-1:0] center_reg;
    logic [STEP_W-1:0]   step_reg;

    logic rx_fire;
    logic last_byte;
    logic out_load;
    logic s1_free;

    assign last_byte = pos_reg[2];
    assign out_load  = !res_valid_reg || res.ready;
    assign s1_free   = !s1_valid_reg || out_load;
    assign rx.ready  = !last_byte || s1_free;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        pos_next = pos_reg;
        if (rx_fire)
        begin
            pos_next = last_byte ? '0 : pos_reg + 3'd1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_fire && last_byte)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign res_valid_next = out_load ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            center_reg    <= CENTER_RESET;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            pos_reg       <= pos_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_CENTER: center_reg <= cfg.data[CENTER_W-1:0];
                    CFG_STEP:   step_reg   <= cfg.data[STEP_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && !last_byte)
        begin
            held_reg[pos_reg[1:0]] <= rx.rx_byte;
        end
        if (rx_fire && last_byte)
        begin
            s1_cmd_reg <= {rx.rx_byte, held_reg[3], held_reg[2], held_reg[1], held_reg[0]};
        end
        if (out_load && s1_valid_reg)
        begin
            res_data_reg <= dec_result;
        end
    end

    sled_decode u_decode (
        .cmd    (s1_cmd_reg),
        .center (center_reg),
        .step   (step_reg),
        .result (dec_result)
    );

    assign res.valid         = res_valid_reg;
    assign res.command_valid = res_data_reg.command_valid;
    assign res.target_kind   = res_data_reg.target_kind;
    assign res.channel       = res_data_reg.channel;
    assign res.compare_value = res_data_reg.compare_value;
    assign res.led_level     = res_data_reg.led_level;

    `SLED_ASSERT_ALWAYS(a_pos_range, pos_reg <= 3'd4, "character position beyond fifth byte")
    `SLED_ASSERT_NEXT(a_fifth_capture, rx_fire && last_byte, s1_valid_reg && (pos_reg == 3'd0),
        "fifth byte did not start a decode")
    `SLED_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_load, s1_valid_reg,
        "pending command lost while output stalled")
    `SLED_ASSERT_SAME(a_invalid_clear, res.valid && !res.command_valid,
        (res.compare_value == '0) && !res.led_level && (res.channel == '0),
        "invalid result carries data")

endmodule
